// ===== design/hspl_pkg.sv =====
// ----------------------------------------------------------------------------
// hspl_pkg
// Shared types and constants of the Huffman sorted priority list.
// ----------------------------------------------------------------------------
package hspl_pkg;

  localparam int CAPACITY    = 256;
  localparam int FREQ_W      = 32;
  localparam int TAG_W       = 9;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int SCAN_LEVELS = $clog2(CAPACITY);

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_POP    = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP,
    CELL_CLEAR
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_e;

  typedef struct packed {
    logic              valid;
    logic [FREQ_W-1:0] freq;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  typedef struct packed {
    cell_op_e          op;
    logic              is_load;
    logic [FREQ_W-1:0] freq;
    logic [TAG_W-1:0]  tag;
  } cell_ctrl_t;

endpackage

// ===== design/hspl_cell.sv =====
// ----------------------------------------------------------------------------
// hspl_cell
// One slot of the sorted list. Compares its entry against the new word and
// shifts up, shifts down, keeps, clears or takes the new word as the row commands.
// ----------------------------------------------------------------------------
module hspl_cell
  import hspl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     lower_i,
  input  entry_t     upper_i,
  input  logic       keep_i,
  input  logic       keep_low_i,
  output entry_t     entry_o,
  output logic       hit_o
);

  logic              valid_q, valid_d;
  logic [FREQ_W-1:0] freq_q, freq_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic              hit_q, hit_d;

  always_comb begin
    if (ctrl_i.is_load) begin
      hit_d = valid_q && ((freq_q < ctrl_i.freq) ||
                          ((freq_q == ctrl_i.freq) && (tag_q > ctrl_i.tag)));
    end else begin
      hit_d = valid_q && (freq_q <= ctrl_i.freq);
    end
  end

  always_comb begin
    valid_d = valid_q;
    freq_d  = freq_q;
    tag_d   = tag_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (!keep_i) begin
          if (keep_low_i) begin
            valid_d = 1'b1;
            freq_d  = ctrl_i.freq;
            tag_d   = ctrl_i.tag;
          end else begin
            valid_d = lower_i.valid;
            freq_d  = lower_i.freq;
            tag_d   = lower_i.tag;
          end
        end
      end
      CELL_POP: begin
        valid_d = upper_i.valid;
        freq_d  = upper_i.freq;
        tag_d   = upper_i.tag;
      end
      CELL_CLEAR: begin
        valid_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    freq_q <= freq_d;
    tag_q  <= tag_d;
  end

  assign entry_o = '{valid: valid_q, freq: freq_q, tag: tag_q};
  assign hit_o   = hit_q;

endmodule

// ===== design/hspl_scan.sv =====
// ----------------------------------------------------------------------------
// hspl_scan
// Suffix OR over the cell hit flags: bit j is set when any cell at or above
// j matched, which marks the cells that keep their entry on an insert.
// ----------------------------------------------------------------------------
module hspl_scan
  import hspl_pkg::*;
(
  input  logic [CAPACITY-1:0] hit_i,
  output logic [CAPACITY-1:0] keep_o
);

  logic [CAPACITY-1:0] lvl [SCAN_LEVELS+1];

  assign lvl[0] = hit_i;

  for (genvar l = 0; l < SCAN_LEVELS; l++) begin : g_lvl
    assign lvl[l+1] = lvl[l] | (lvl[l] >> (1 << l));
  end

  assign keep_o = lvl[SCAN_LEVELS];

endmodule

// ===== design/huffman_sorted_priority_list_unit.sv =====
// ----------------------------------------------------------------------------
// huffman_sorted_priority_list_unit
// Sorted (frequency, tag) list for Huffman tree building, held in a row of
// cells with the smallest entry in cell 0.
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+-------------------------------
//   in      | input     | in_valid_i/in_ready_o  | func, freq, node_tag
//   out     | output    | out_valid_o/out_ready_i| popped_freq, popped_tag,
//           |           |                        | entry_total, status
//
// Each word passes three steps: accept, cell compare, then suffix scan and
// shift of the cell row; a new word is taken the cycle after the shift.
// The result register frees the input side: the next word is accepted while
// a result waits, and the shift stalls only while that result is not taken.
// Reset empties the list at once through the per-cell valid bits.
// ----------------------------------------------------------------------------
module huffman_sorted_priority_list_unit
  import hspl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        func_i,
  input  logic [FREQ_W-1:0] freq_i,
  input  logic [TAG_W-1:0]  node_tag_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [FREQ_W-1:0] popped_freq_o,
  output logic [TAG_W-1:0]  popped_tag_o,
  output logic [CNT_W-1:0]  entry_total_o,
  output logic [1:0]        status_o
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  state_e              state_q, state_d;
  func_e               func_q;
  logic [FREQ_W-1:0]   freq_q;
  logic [TAG_W-1:0]    tag_q;
  logic [CNT_W-1:0]    count_q, count_d;

  logic                out_valid_q;
  logic [FREQ_W-1:0]   pfreq_q, pfreq_d;
  logic [TAG_W-1:0]    ptag_q, ptag_d;
  logic [CNT_W-1:0]    total_q;
  status_e             status_q, status_d;

  logic                in_fire;
  logic                do_upd;
  cell_op_e            op;
  cell_ctrl_t          ctrl;
  entry_t              entries [CAPACITY];
  logic [CAPACITY-1:0] hits;
  logic [CAPACITY-1:0] keep;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign do_upd     = (state_q == ST_UPD) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_CMP;
      ST_CMP:  state_d = ST_UPD;
      ST_UPD:  if (do_upd) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    op       = CELL_HOLD;
    count_d  = count_q;
    status_d = STAT_OK;
    pfreq_d  = '0;
    ptag_d   = '0;
    case (func_q)
      FUNC_LOAD: begin
        if (freq_q != '0) begin
          if (count_q == CAP_CNT) begin
            status_d = STAT_FULL;
          end else begin
            op      = CELL_INSERT;
            count_d = count_q + CNT_W'(1);
          end
        end
      end
      FUNC_INSERT: begin
        if (count_q == CAP_CNT) begin
          status_d = STAT_FULL;
        end else begin
          op      = CELL_INSERT;
          count_d = count_q + CNT_W'(1);
        end
      end
      FUNC_POP: begin
        if (count_q == '0) begin
          status_d = STAT_EMPTY;
        end else begin
          op      = CELL_POP;
          count_d = count_q - CNT_W'(1);
          pfreq_d = entries[0].freq;
          ptag_d  = entries[0].tag;
        end
      end
      FUNC_CLEAR: begin
        op      = CELL_CLEAR;
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  assign ctrl = '{op:      (do_upd ? op : CELL_HOLD),
                  is_load: (func_q == FUNC_LOAD),
                  freq:    freq_q,
                  tag:     tag_q};

  hspl_scan u_scan (
    .hit_i  (hits),
    .keep_o (keep)
  );

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    entry_t lower;
    entry_t upper;
    logic   keep_low;

    if (j == 0) begin : g_bot
      assign lower    = '0;
      assign keep_low = 1'b1;
    end else begin : g_mid
      assign lower    = entries[j-1];
      assign keep_low = keep[j-1];
    end

    if (j == CAPACITY - 1) begin : g_top
      assign upper = '0;
    end else begin : g_low
      assign upper = entries[j+1];
    end

    hspl_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .lower_i    (lower),
      .upper_i    (upper),
      .keep_i     (keep[j]),
      .keep_low_i (keep_low),
      .entry_o    (entries[j]),
      .hit_o      (hits[j])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (do_upd) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= func_e'(func_i);
      freq_q <= freq_i;
      tag_q  <= node_tag_i;
    end
    if (do_upd) begin
      pfreq_q  <= pfreq_d;
      ptag_q   <= ptag_d;
      total_q  <= count_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign popped_freq_o = pfreq_q;
  assign popped_tag_o  = ptag_q;
  assign entry_total_o = total_q;
  assign status_o      = status_q;

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for huffman_sorted_priority_list_unit. A queue model
// of the sorted list predicts each result word as its input word is taken.
// A checker compares each returned word, field by field, with the oldest
// prediction. Stimulus runs directed corner cases, a fill to capacity,
// Huffman tree builds and a random operation mix, under several sender and
// receiver idle mixes.
// ----------------------------------------------------------------------------
module tb;
  import hspl_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [TAG_W-1:0]  tag;
  } slot_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [TAG_W-1:0]  tag;
    logic [CNT_W-1:0]  total;
    status_e           status;
  } pop_word_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  func_e             func      = FUNC_CLEAR;
  logic [FREQ_W-1:0] freq      = '0;
  logic [TAG_W-1:0]  node_tag  = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [FREQ_W-1:0] popped_freq;
  logic [TAG_W-1:0]  popped_tag;
  logic [CNT_W-1:0]  entry_total;
  logic [1:0]        status;

  slot_t     sorted_list[$];
  pop_word_t pending_words[$];
  pop_word_t last_word;
  pop_word_t arrived_expect;

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int errors             = 0;
  int words_sent         = 0;
  int words_checked      = 0;
  int full_hits          = 0;
  int empty_hits         = 0;
  int trees_built        = 0;
  int cycle_count        = 0;

  huffman_sorted_priority_list_unit dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .func_i       (func),
    .freq_i       (freq),
    .node_tag_i   (node_tag),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .popped_freq_o(popped_freq),
    .popped_tag_o (popped_tag),
    .entry_total_o(entry_total),
    .status_o     (status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  function automatic pop_word_t apply_word(func_e f, logic [FREQ_W-1:0] fr,
                                           logic [TAG_W-1:0] tg);
    pop_word_t w;
    slot_t     s;
    int        pos;
    bit        found;
    w        = '0;
    w.status = STAT_OK;
    s.freq   = fr;
    s.tag    = tg;
    case (f)
      FUNC_LOAD, FUNC_INSERT: begin
        if (f == FUNC_LOAD && fr == '0) begin
          w.status = STAT_OK;
        end else if (sorted_list.size() >= CAPACITY) begin
          w.status = STAT_FULL;
        end else begin
          pos   = 0;
          found = 1'b0;
          while (pos < sorted_list.size() && !found) begin
            if (f == FUNC_INSERT)
              found = (sorted_list[pos].freq <= fr);
            else
              found = (sorted_list[pos].freq < fr) ||
                      (sorted_list[pos].freq == fr && sorted_list[pos].tag > tg);
            if (!found) pos++;
          end
          sorted_list.insert(pos, s);
        end
      end
      FUNC_POP: begin
        if (sorted_list.size() == 0) begin
          w.status = STAT_EMPTY;
        end else begin
          s      = sorted_list.pop_back();
          w.freq = s.freq;
          w.tag  = s.tag;
        end
      end
      default: begin
        sorted_list.delete();
      end
    endcase
    w.total = CNT_W'(sorted_list.size());
    return w;
  endfunction

  function automatic void check_field(string name, logic [FREQ_W-1:0] exp_val,
                                      logic [FREQ_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val,
               act_val);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, got freq %0h tag %0h total %0d status %0d",
                 $time, popped_freq, popped_tag, entry_total, status);
        errors++;
      end else begin
        arrived_expect = pending_words.pop_front();
        check_field("popped_freq", arrived_expect.freq, popped_freq);
        check_field("popped_tag", FREQ_W'(arrived_expect.tag), FREQ_W'(popped_tag));
        check_field("entry_total", FREQ_W'(arrived_expect.total), FREQ_W'(entry_total));
        check_field("status", FREQ_W'(arrived_expect.status), FREQ_W'(status));
        if (arrived_expect.status == STAT_FULL) full_hits++;
        if (arrived_expect.status == STAT_EMPTY) empty_hits++;
        words_checked++;
      end
    end
  end

  task automatic send_word(input func_e f, input logic [FREQ_W-1:0] fr,
                           input logic [TAG_W-1:0] tg);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    freq     <= fr;
    node_tag <= tg;
    do @(posedge clk); while (!in_ready);
    last_word = apply_word(f, fr, tg);
    pending_words.push_back(last_word);
    words_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  function automatic logic [FREQ_W-1:0] rand_freq();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return FREQ_W'($urandom_range(1, 8));
      5, 6:    return FREQ_W'($urandom_range(255));
      default: return FREQ_W'($urandom);
    endcase
  endfunction

  function automatic logic [TAG_W-1:0] rand_tag();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return TAG_W'($urandom_range(3));
      default: return TAG_W'($urandom_range(511));
    endcase
  endfunction

  function automatic func_e rand_func();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return FUNC_LOAD;
    if (pick < 60) return FUNC_INSERT;
    if (pick < 97) return FUNC_POP;
    return FUNC_CLEAR;
  endfunction

  task automatic test_directed();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_word(FUNC_POP, '0, '0);
    send_word(FUNC_LOAD, '0, 9'd5);
    send_word(FUNC_LOAD, '1, '1);
    send_word(FUNC_LOAD, 32'd1, '0);
    send_word(FUNC_LOAD, 32'd7, 9'd3);
    send_word(FUNC_LOAD, 32'd7, 9'd9);
    send_word(FUNC_LOAD, 32'd7, 9'd3);
    send_word(FUNC_INSERT, 32'd7, 9'd100);
    send_word(FUNC_INSERT, '0, 9'd200);
    send_word(FUNC_INSERT, '1, '0);
    repeat (9) send_word(FUNC_POP, '1, '1);
    send_word(FUNC_LOAD, 32'd5, 9'd1);
    send_word(FUNC_LOAD, 32'd3, 9'd2);
    send_word(FUNC_CLEAR, '0, '0);
    send_word(FUNC_POP, '0, '0);
    send_word(FUNC_INSERT, 32'hAAAA_AAAA, 9'h155);
    send_word(FUNC_LOAD, 32'h5555_5555, 9'h0AA);
    wait_for_results();
  endtask

  task automatic test_fill_to_capacity();
    send_word(FUNC_CLEAR, rand_freq(), rand_tag());
    while (sorted_list.size() < CAPACITY)
      send_word($urandom_range(3) == 0 ? FUNC_INSERT : FUNC_LOAD, rand_freq(), rand_tag());
    send_word(FUNC_LOAD, '1, rand_tag());
    send_word(FUNC_INSERT, '0, rand_tag());
    send_word(FUNC_LOAD, '0, rand_tag());
    send_word(FUNC_INSERT, rand_freq(), rand_tag());
    repeat (16) send_word(FUNC_POP, rand_freq(), rand_tag());
    send_word(FUNC_CLEAR, rand_freq(), rand_tag());
    wait_for_results();
  endtask

  task automatic test_huffman_builds(input int budget);
    int                first_word;
    int                leaves;
    logic [FREQ_W-1:0] left_freq;
    logic [TAG_W-1:0]  node_id;
    first_word = words_sent;
    while (words_sent - first_word < budget) begin
      leaves  = $urandom_range(2, 24);
      node_id = 9'd256;
      send_word(FUNC_CLEAR, '0, '0);
      repeat (leaves)
        send_word(FUNC_LOAD, $urandom_range(7) == 0 ? FREQ_W'($urandom) | 1'b1 :
                  FREQ_W'($urandom_range(1, 40)), TAG_W'($urandom_range(255)));
      while (sorted_list.size() > 1) begin
        send_word(FUNC_POP, '0, '0);
        left_freq = last_word.freq;
        send_word(FUNC_POP, '0, '0);
        send_word(FUNC_INSERT, left_freq + last_word.freq, node_id);
        node_id++;
      end
      send_word(FUNC_POP, '0, '0);
      trees_built++;
    end
    wait_for_results();
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) send_word(rand_func(), rand_freq(), rand_tag());
    wait_for_results();
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("huffman_sorted_priority_list_unit verification failed");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();

    sender_idle_pct    = 9;
    receiver_stall_pct = 9;
    test_fill_to_capacity();

    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    test_huffman_builds(100);
    test_random_mix(100);

    sender_idle_pct    = 86;
    receiver_stall_pct = 0;
    test_huffman_builds(100);
    test_random_mix(100);

    sender_idle_pct    = 0;
    receiver_stall_pct = 86;
    test_huffman_builds(100);
    test_random_mix(100);

    sender_idle_pct    = 9;
    receiver_stall_pct = 9;
    test_huffman_builds(100);
    test_random_mix(100);

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d words and checked %0d results; %0d full and %0d empty errors seen.",
             words_sent, words_checked, full_hits, empty_hits);
    $display("Covered corner cases, a fill to capacity, %0d tree builds and random mixes.",
             trees_built);
    if (errors == 0) begin
      $display("huffman_sorted_priority_list_unit verification clean");
    end else begin
      $display("huffman_sorted_priority_list_unit verification failed");
    end
    $finish;
  end

endmodule
